// ----- design/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types, codes and default words of the shadow register dirty flush core
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int WORD_COUNT = 6;
	localparam int IDX_W      = 3;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_W     = 2;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_FLUSH   = 2'd1;
	localparam logic [1:0] MODE_STARTUP = 2'd2;

	localparam logic [4:0]  MIN_LOW_BIT      = 5'd3;
	localparam logic [31:0] OUTPUTS_OFF_MASK = 32'hFFFF_FEDF;
	localparam logic [WORD_COUNT-1:0] ALL_DIRTY = 6'h3F;
	localparam logic [IDX_W-1:0] WAIT_IDX = 3'd5;
	localparam logic [IDX_W-1:0] OFF_IDX  = 3'd4;

	localparam logic [31:0] DEFAULT_WORDS [WORD_COUNT] = '{
		32'h001D_1740, 32'h4001_7FE1, 32'h8000_5F42,
		32'h0000_1F23, 32'h63EE_81FC, 32'h0040_0005
	};

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  reg_index;
		logic [4:0]  bit_high;
		logic [4:0]  bit_low;
		logic [31:0] field_value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] spi_word;
		logic [2:0]  register_number;
		logic        wait_after;
		logic        last_word;
	} out_word_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_FLUSH,
		CMD_STARTUP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      mask;
		logic [31:0]      value;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WRITE,
		BK_EMIT
	} back_state_t;

endpackage

// ----- design/sdf_front.sv -----
// ----------------------------------------------------------------------------
// sdf_front
// decodes input words into back-end commands, drops rejected writes
// ----------------------------------------------------------------------------
module sdf_front (
	input  sdf_pkg::in_word_t in_word,
	output logic              cmd_keep,
	output sdf_pkg::cmd_t     cmd
);
	import sdf_pkg::*;

	logic [4:0] lo;
	logic [4:0] hi;
	logic       write_ok;

	always_comb begin
		if (in_word.bit_low > in_word.bit_high) begin
			lo = in_word.bit_high;
			hi = in_word.bit_low;
		end else begin
			lo = in_word.bit_low;
			hi = in_word.bit_high;
		end
		write_ok = (lo >= MIN_LOW_BIT) && (in_word.reg_index < IDX_W'(WORD_COUNT));

		for (int b = 0; b < 32; b++) begin
			cmd.mask[b] = (5'(b) >= lo) && (5'(b) <= hi);
		end
		cmd.value = in_word.field_value << lo;
		cmd.idx   = in_word.reg_index;
		cmd.op    = CMD_WRITE;
		cmd_keep  = 1'b0;

		unique case (in_word.mode)
			MODE_WRITE: begin
				cmd.op   = CMD_WRITE;
				cmd_keep = write_ok;
			end
			MODE_FLUSH: begin
				cmd.op   = CMD_FLUSH;
				cmd_keep = 1'b1;
			end
			MODE_STARTUP: begin
				cmd.op   = CMD_STARTUP;
				cmd_keep = 1'b1;
			end
			default: begin
				cmd.op   = CMD_WRITE;
				cmd_keep = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/sdf_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// sdf_cmd_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module sdf_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sdf_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output sdf_pkg::cmd_t head_cmd
);
	import sdf_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("command popped from empty queue");

endmodule

// ----- design/sdf_back.sv -----
// ----------------------------------------------------------------------------
// sdf_back
// shadow words, dirty mask and serial word emission
// ----------------------------------------------------------------------------
module sdf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  sdf_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output sdf_pkg::out_word_t out_word
);
	import sdf_pkg::*;

	back_state_t           state_q, state_nxt;
	logic [31:0]           shadow_q [WORD_COUNT];
	logic [WORD_COUNT-1:0] dirty_q, dirty_nxt;
	logic [WORD_COUNT-1:0] run_q, run_nxt;
	logic                  first_pass_q, first_pass_nxt;
	cmd_t                  cmd_q;
	logic                  out_valid_q, out_valid_nxt;
	out_word_t             out_word_q;

	logic [IDX_W-1:0]      top_idx;
	logic [IDX_W-1:0]      rd_idx;
	logic [31:0]           rd_word;
	logic [31:0]           new_word;
	logic                  changed;
	logic                  do_write;
	logic                  do_emit;
	logic                  do_restore;
	logic [WORD_COUNT-1:0] top_hot;
	logic [WORD_COUNT-1:0] run_left;
	out_word_t             emit_word;

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < WORD_COUNT; i++) begin
			if (run_q[i]) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign rd_idx   = (state_q == BK_WRITE) ? cmd_q.idx : top_idx;
	assign rd_word  = shadow_q[rd_idx];
	assign new_word = (rd_word & ~cmd_q.mask) | (cmd_q.value & cmd_q.mask);
	assign changed  = (new_word != rd_word);
	assign top_hot  = WORD_COUNT'(1) << top_idx;
	assign run_left = run_q & ~top_hot;

	always_comb begin
		state_nxt      = state_q;
		dirty_nxt      = dirty_q;
		run_nxt        = run_q;
		first_pass_nxt = first_pass_q;
		cmd_pop        = 1'b0;
		do_write       = 1'b0;
		do_emit        = 1'b0;
		do_restore     = 1'b0;
		out_valid_nxt  = out_valid_q && out_stall;

		emit_word.spi_word        = rd_word;
		emit_word.register_number = top_idx;
		emit_word.wait_after      = first_pass_q && (top_idx == WAIT_IDX);
		emit_word.last_word       = (run_left == '0) && !first_pass_q;
		if (first_pass_q && (top_idx == OFF_IDX)) begin
			emit_word.spi_word = rd_word & OUTPUTS_OFF_MASK;
		end

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						CMD_WRITE: begin
							state_nxt = BK_WRITE;
						end
						CMD_FLUSH: begin
							dirty_nxt = '0;
							run_nxt   = dirty_q;
							if (dirty_q != '0) begin
								state_nxt = BK_EMIT;
							end
						end
						CMD_STARTUP: begin
							do_restore     = 1'b1;
							dirty_nxt      = '0;
							run_nxt        = ALL_DIRTY;
							first_pass_nxt = 1'b1;
							state_nxt      = BK_EMIT;
						end
						default: begin
							state_nxt = BK_IDLE;
						end
					endcase
				end
			end
			BK_WRITE: begin
				do_write = changed;
				if (changed) begin
					dirty_nxt = dirty_q | (WORD_COUNT'(1) << cmd_q.idx);
				end
				dirty_nxt[0] = dirty_nxt[0] | dirty_nxt[1] | dirty_nxt[4];
				state_nxt    = BK_IDLE;
			end
			BK_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					do_emit       = 1'b1;
					out_valid_nxt = 1'b1;
					run_nxt       = run_left;
					if (run_left == '0) begin
						if (first_pass_q) begin
							run_nxt        = ALL_DIRTY;
							first_pass_nxt = 1'b0;
						end else begin
							state_nxt = BK_IDLE;
						end
					end
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			dirty_q      <= '0;
			run_q        <= '0;
			first_pass_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < WORD_COUNT; i++) begin
				shadow_q[i] <= DEFAULT_WORDS[i];
			end
		end else begin
			state_q      <= state_nxt;
			dirty_q      <= dirty_nxt;
			run_q        <= run_nxt;
			first_pass_q <= first_pass_nxt;
			out_valid_q  <= out_valid_nxt;
			if (do_restore) begin
				for (int i = 0; i < WORD_COUNT; i++) begin
					shadow_q[i] <= DEFAULT_WORDS[i];
				end
			end else if (do_write) begin
				shadow_q[cmd_q.idx] <= new_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (do_emit) begin
			out_word_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_dirty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q[1] || dirty_q[4]) |-> dirty_q[0])
		else $error("word 0 not dirty while word 1 or 4 is");

	a_run_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q != '0) |-> (state_q == BK_EMIT))
		else $error("pending words outside emission");

	a_wait_on_five: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.wait_after) |->
		(out_word_q.register_number == WAIT_IDX) && !out_word_q.last_word)
		else $error("wait marker on wrong word");

endmodule

// ----- design/shadow_register_dirty_flush_core.sv -----
// ----------------------------------------------------------------------------
// shadow_register_dirty_flush_core
// six-word shadow register file with dirty mask and serial flush
// ----------------------------------------------------------------------------
// A field write pops its command, then merges and compares it against the
// selected shadow word, and emits nothing. A flush emits each dirty word; a
// reset-and-start-up emits twelve words. Words leave one per cycle from the
// output register unless stall is held. A two-entry command queue lets the
// input side keep taking words while the back end emits, so input stall rises
// only when the queue is full.
module shadow_register_dirty_flush_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sdf_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output sdf_pkg::out_word_t out_word
);
	import sdf_pkg::*;

	cmd_t dec_cmd;
	cmd_t head_cmd;
	logic dec_keep;
	logic q_full;
	logic q_avail;
	logic q_pop;
	logic q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && dec_keep;

	sdf_front u_front (
		.in_word  (in_word),
		.cmd_keep (dec_keep),
		.cmd      (dec_cmd)
	);

	sdf_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (dec_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_avail),
		.head_cmd  (head_cmd)
	);

	sdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_avail),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
